// ----- hdl/bpf_pkg.sv -----
// shared types and constants for the bgr555 palette fade block
package bpf_pkg;

  localparam int CH_W      = 5;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int ENTRY_W   = 9;
  localparam int BANK_SH   = 4;
  localparam int BANK_W    = ENTRY_W - BANK_SH;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CH_W-1:0] CH_MAX = 5'd31;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_AMOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MASK    = 2'd3;

  typedef enum logic [1:0] {
    MODE_COPY  = 2'd0,
    MODE_BLACK = 2'd1,
    MODE_WHITE = 2'd2,
    MODE_GRAY  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_in;
    logic [ENTRY_W-1:0] entry_index;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_out;
    logic [ENTRY_W-1:0] entry_out;
    logic               write_enable;
    logic               last_out;
  } out_item_t;

endpackage

// ----- hdl/bpf_stream_if.sv -----
// valid/ready stream channel carrying one item per handshake
interface bpf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/bgr555_palette_fade.sv -----
// top level of the bgr555 palette fade block
//
// usage:
//   in_if  : valid/ready stream of items {color_in, entry_index, last_in}
//   out_if : valid/ready stream of items {color_out, entry_out, write_enable, last_out}
//   cfg_*  : plain write port, cfg_we writes cfg_wdata into register cfg_idx
//            (0 effect_mode, 1 fade_amount, 2 bank_enable_mask, 3 use_bank_mask)
// every item gives exactly one result item, in order
// an accepted item goes through the input register and then the result register before out_if shows it
// throughput: one item per cycle while out_if is not stalled, set by the two-stage register pipeline
//   (input register, then the per-channel multiply into the result register)
// when the receiver stalls the result register holds; the input register
//   still takes one more item, after that in_if.ready drops until out_if drains
// reset clears both stage valid bits and all configuration registers to 0
// configuration must only be changed by the user while no item is in flight; the block does not enforce this
module bgr555_palette_fade #(
  parameter int PALETTE_ENTRIES = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bpf_stream_if.sink                 in_if,
  bpf_stream_if.source               out_if,
  input  logic                       cfg_we,
  input  logic [bpf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bpf_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import bpf_pkg::*;

  // wide enough to hold the largest palette size
  localparam int LIM_W = $clog2(PALETTE_ENTRIES + 1);
  localparam int CMP_W = (LIM_W > ENTRY_W) ? LIM_W : ENTRY_W;
  localparam logic [CMP_W-1:0] ENTRY_LIMIT = CMP_W'(PALETTE_ENTRIES);

  // configuration registers
  mode_t                 effect_mode_r;
  logic [CH_W-1:0]       fade_amount_r;
  logic [CFG_DAT_W-1:0]  bank_mask_r;
  logic                  use_mask_r;

  // pipeline registers
  logic       s1_valid_r;
  in_item_t   s1_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  out_data_nxt;

  logic adv;   // stage 1 moves into the result register
  logic s1_load;

  // ---------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_mode_r <= MODE_COPY;
      fade_amount_r <= '0;
      bank_mask_r   <= '0;
      use_mask_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_EFFECT_MODE: effect_mode_r <= mode_t'(cfg_wdata[1:0]);
        REG_FADE_AMOUNT: fade_amount_r <= cfg_wdata[CH_W-1:0];
        REG_BANK_MASK:   bank_mask_r   <= cfg_wdata;
        REG_USE_MASK:    use_mask_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: result register frees when empty or taken, input register
  // frees when empty or moving on
  assign adv          = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || adv;
  assign s1_load      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_if.data;
    end
  end

  // ---------------------------------------------------------------------
  // per-channel effect arithmetic
  function automatic logic [CH_W-1:0] to_black(input logic [CH_W-1:0] c,
                                                input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] p;
    p = a * c;
    return c - p[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [CH_W-1:0] to_white(input logic [CH_W-1:0] c,
                                                input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] p;
    p = (CH_MAX - c) * a;
    return c + p[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [CH_W-1:0] to_gray(input logic [CH_W-1:0]   c,
                                               input logic [2*CH_W-1:0] grayw,
                                               input logic [CH_W-1:0]   a);
    logic [2*CH_W:0] s;
    s = {1'b0, grayw} + (2*CH_W+1)'(c * (CH_MAX - a));
    return s[2*CH_W-1:CH_W];
  endfunction

  always_comb begin
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
    logic [CH_W+1:0]    sum;
    logic [2*CH_W-1:0]  grayw;
    logic [BANK_W-1:0]  bank;
    logic               enabled;
    logic               in_range;

    r        = s1_data_r.color_in[CH_W-1:0];
    g        = s1_data_r.color_in[2*CH_W-1:CH_W];
    b        = s1_data_r.color_in[3*CH_W-1:2*CH_W];
    sum      = (CH_W+2)'(r) + (CH_W+2)'(g) + (CH_W+2)'(b);
    grayw    = (2*CH_W)'(sum[CH_W+1:2] * fade_amount_r);
    bank     = s1_data_r.entry_index[ENTRY_W-1:BANK_SH];
    enabled  = !use_mask_r || bank_mask_r[bank];
    in_range = CMP_W'(s1_data_r.entry_index) < ENTRY_LIMIT;

    out_data_nxt.color_out    = s1_data_r.color_in;
    out_data_nxt.entry_out    = s1_data_r.entry_index;
    out_data_nxt.write_enable = enabled && in_range;
    out_data_nxt.last_out     = s1_data_r.last_in;

    // masked banks pass through untouched
    if (enabled) begin
      case (effect_mode_r)
        MODE_BLACK: begin
          out_data_nxt.color_out = {to_black(b, fade_amount_r),
                                    to_black(g, fade_amount_r),
                                    to_black(r, fade_amount_r)};
        end
        MODE_WHITE: begin
          out_data_nxt.color_out = {to_white(b, fade_amount_r),
                                    to_white(g, fade_amount_r),
                                    to_white(r, fade_amount_r)};
        end
        MODE_GRAY: begin
          out_data_nxt.color_out = {to_gray(b, grayw, fade_amount_r),
                                    to_gray(g, grayw, fade_amount_r),
                                    to_gray(r, grayw, fade_amount_r)};
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // checks

  // an entry beyond the palette is never marked written
  a_we_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.write_enable |->
      (CMP_W'(out_data_r.entry_out) < ENTRY_LIMIT))
    else $error("write_enable set for entry outside the palette");

  // an accepted item always lands in the input register
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_valid_r)
    else $error("accepted item lost from input register");

  // a waiting item in the input register is not overwritten or dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register changed while blocked");

  // moving an item forward always produces a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item did not reach result register");

endmodule
